// ----- design/assert_macros.svh -----
// assert_macros.svh: assertion macros used by the checker file rbrt_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define RBRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form on the top-level clock and reset
`define RBRT_ASSERT_IMP(label, ante, cons, msg) \
    `RBRT_ASSERT(label, i_clk, i_rst_n, (ante) |-> (cons), msg)

`endif

// ----- design/rbrt_pkg.sv -----
// rbrt_pkg: action codes, size kinds and range helpers for the read buffer table.
// No dependencies.
package rbrt_pkg;

    typedef enum logic [1:0] {
        ACT_SEARCH  = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_INV_ONE = 2'd2,
        ACT_INV_ALL = 2'd3
    } t_action;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_4    = 2'd1;
    localparam logic [1:0] KIND_16   = 2'd2;
    localparam logic [1:0] KIND_32   = 2'd3;

    function automatic logic [5:0] kind_bytes(input logic [1:0] kind);
        logic [5:0] bytes;
        unique case (kind)
            KIND_NONE: bytes = 6'd0;
            KIND_4:    bytes = 6'd4;
            KIND_16:   bytes = 6'd16;
            KIND_32:   bytes = 6'd32;
            default:   bytes = 6'd0;
        endcase
        return bytes;
    endfunction

    // aligned base; an invalid kind clears the whole address
    function automatic logic [31:0] align_base(input logic [31:0] addr, input logic [1:0] kind);
        logic [31:0] base;
        unique case (kind)
            KIND_NONE: base = 32'd0;
            KIND_4:    base = {addr[31:2], 2'b00};
            KIND_16:   base = {addr[31:4], 4'b0000};
            KIND_32:   base = {addr[31:5], 5'b00000};
            default:   base = 32'd0;
        endcase
        return base;
    endfunction

endpackage

// ----- design/read_buffer_range_table.sv -----
// read_buffer_range_table: MMU read-buffer table with one shared range comparator.
// Search: scans from entry 0 until a hit or the last entry, result beat on the cycle after the scan ends.
// Load (index in range): scans every entry, then one result beat. Invalidate: result beat next cycle.
// One item at a time; busy is high during the scan, next beat taken in the result cycle.
// Synchronous active-low reset clears all entries to invalid and the sequencer to idle.
module read_buffer_range_table #(
    parameter int ENTRIES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_address,
    input  logic [1:0]  i_entry_index,
    input  logic [1:0]  i_buffer_size,
    input  logic [3:0]  i_fault_code,
    output logic        o_done,
    output logic        o_hit,
    output logic [1:0]  o_hit_index,
    output logic [3:0]  o_hit_fault
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [IW-1:0]          r_cnt;
    rbrt_pkg::t_action      r_act;
    logic [IW-1:0]          r_idx;
    logic [1:0]             r_kind_new;
    logic [3:0]             r_fault_new;
    logic [31:0]            r_q_lo;
    logic [32:0]            r_q_hi;

    logic [1:0]             r_kind  [ENTRIES];
    logic [31:0]            r_base  [ENTRIES];
    logic [3:0]             r_fault [ENTRIES];

    logic                   r_done;
    logic                   r_hit;
    logic [1:0]             r_hit_index;
    logic [3:0]             r_hit_fault;

    logic                   w_accept;
    logic                   w_idx_ok;
    logic                   w_quick;
    logic [31:0]            w_nb;
    logic [1:0]             w_kind;
    logic [31:0]            w_base;
    logic [32:0]            w_end;
    logic                   w_match;
    logic                   w_last;
    logic                   w_finish;

    assign busy     = (r_state == ST_SCAN);
    assign w_accept = start && !busy;
    assign w_idx_ok = (32'(i_entry_index) < ENTRIES);
    assign w_nb     = rbrt_pkg::align_base(i_address, i_buffer_size);

    // beats answered without a scan
    assign w_quick  = w_accept
                      && (rbrt_pkg::t_action'(i_action) == rbrt_pkg::ACT_INV_ONE
                      || rbrt_pkg::t_action'(i_action) == rbrt_pkg::ACT_INV_ALL
                      || (rbrt_pkg::t_action'(i_action) == rbrt_pkg::ACT_LOAD && !w_idx_ok));

    // shared range comparator on entry r_cnt against query [r_q_lo, r_q_hi)
    assign w_kind  = r_kind[r_cnt];
    assign w_base  = r_base[r_cnt];
    assign w_end   = {1'b0, w_base} + 33'(rbrt_pkg::kind_bytes(w_kind));
    assign w_match = (w_kind != rbrt_pkg::KIND_NONE) && ({1'b0, w_base} < r_q_hi)
                     && ({1'b0, r_q_lo} < w_end);
    assign w_last  = (r_cnt == LAST);
    assign w_finish = busy && (w_last || (r_act == rbrt_pkg::ACT_SEARCH && w_match));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (rbrt_pkg::t_action'(i_action) == rbrt_pkg::ACT_SEARCH
                    || (rbrt_pkg::t_action'(i_action) == rbrt_pkg::ACT_LOAD && w_idx_ok))) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_kind[i]  <= rbrt_pkg::KIND_NONE;
                r_fault[i] <= 4'd0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= w_quick || w_finish;
            if (w_accept) begin
                r_cnt <= '0;
                unique case (rbrt_pkg::t_action'(i_action))
                    rbrt_pkg::ACT_SEARCH, rbrt_pkg::ACT_LOAD: ;
                    rbrt_pkg::ACT_INV_ONE: begin
                        if (w_idx_ok) begin
                            r_kind[IW'(i_entry_index)] <= rbrt_pkg::KIND_NONE;
                        end
                    end
                    rbrt_pkg::ACT_INV_ALL: begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            r_kind[i] <= rbrt_pkg::KIND_NONE;
                        end
                    end
                    default: ;
                endcase
            end
            if (busy) begin
                r_cnt <= r_cnt + IW'(1);
                if (r_act == rbrt_pkg::ACT_LOAD) begin
                    // target entry is rewritten below on the last step
                    if (w_match && !(w_last && r_cnt == r_idx)) begin
                        r_kind[r_cnt] <= rbrt_pkg::KIND_NONE;
                    end
                    if (w_last) begin
                        r_kind[r_idx]  <= r_kind_new;
                        r_fault[r_idx] <= r_fault_new;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act       <= rbrt_pkg::t_action'(i_action);
            r_idx       <= IW'(i_entry_index);
            r_kind_new  <= i_buffer_size;
            r_fault_new <= i_fault_code;
            r_hit       <= 1'b0;
            r_hit_index <= 2'd0;
            r_hit_fault <= 4'd0;
            if (rbrt_pkg::t_action'(i_action) == rbrt_pkg::ACT_SEARCH) begin
                r_q_lo <= i_address;
                r_q_hi <= {1'b0, i_address} + 33'd1;
            end else begin
                r_q_lo <= w_nb;
                r_q_hi <= {1'b0, w_nb} + 33'(rbrt_pkg::kind_bytes(i_buffer_size));
            end
        end
        if (busy && r_act == rbrt_pkg::ACT_SEARCH && w_match) begin
            r_hit       <= 1'b1;
            r_hit_index <= 2'(r_cnt);
            r_hit_fault <= r_fault[r_cnt];
        end
        if (busy && r_act == rbrt_pkg::ACT_LOAD && w_last) begin
            r_base[r_idx] <= r_q_lo;
        end
    end

    assign o_done      = r_done;
    assign o_hit       = r_hit;
    assign o_hit_index = r_hit_index;
    assign o_hit_fault = r_hit_fault;

endmodule

// ----- design/rbrt_checker.sv -----
// rbrt_assert_checker: port-level assertions for read_buffer_range_table, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rbrt_assert_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        o_hit,
    input logic [1:0]  o_hit_index,
    input logic [3:0]  o_hit_fault
);

    logic w_miss_zero;

    assign w_miss_zero = (o_hit_index == 2'd0) && (o_hit_fault == 4'd0);

    // an accepted beat either starts a scan or answers next cycle
    `RBRT_ASSERT(a_accept_go, i_clk, i_rst_n, start && !busy |=> busy || o_done, "no progress")

    // a miss or a non-search beat reports zero index and fault
    `RBRT_ASSERT_IMP(a_miss_zero, o_done && !o_hit, w_miss_zero, "miss with nonzero payload")

    // the result beat comes only once the scan has ended
    `RBRT_ASSERT_IMP(a_done_idle, o_done, !busy, "result beat while busy")

    // a scan always ends in a result beat
    `RBRT_ASSERT(a_scan_ends, i_clk, i_rst_n, $fell(busy) |-> o_done, "scan without result")

endmodule

bind read_buffer_range_table rbrt_assert_checker u_rbrt_checker (.*);
